[design/mips_subset_execute_core_unit_assert.svh]
// assertion macros for the execute core
// used by modules that check their own control; relies on clk and rst in scope
`ifndef MIPS_SUBSET_EXECUTE_CORE_UNIT_ASSERT_SVH
`define MIPS_SUBSET_EXECUTE_CORE_UNIT_ASSERT_SVH

// property holds at every clock outside reset
`define MSEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition never seen outside reset
`define MSEC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[design/msec_pkg.sv]
// shared types and constants of the execute core
// no dependencies
package msec_pkg;

  localparam int DMEM_WORDS  = 1024;
  localparam int DMEM_AW     = $clog2(DMEM_WORDS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_W       = 112;

  localparam logic [5:0] OPC_SPECIAL = 6'h00;
  localparam logic [5:0] OPC_BEQ     = 6'h04;
  localparam logic [5:0] OPC_BNE     = 6'h05;
  localparam logic [5:0] OPC_ADDI    = 6'h08;
  localparam logic [5:0] OPC_ANDI    = 6'h0C;
  localparam logic [5:0] OPC_ORI     = 6'h0D;
  localparam logic [5:0] OPC_XORI    = 6'h0E;
  localparam logic [5:0] OPC_LB      = 6'h20;
  localparam logic [5:0] OPC_LH      = 6'h21;
  localparam logic [5:0] OPC_LW      = 6'h23;
  localparam logic [5:0] OPC_SB      = 6'h28;
  localparam logic [5:0] OPC_SH      = 6'h29;
  localparam logic [5:0] OPC_SW      = 6'h2B;

  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_DIV     = 6'h1A;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;

  typedef enum logic [4:0] {
    K_SLL, K_SRL, K_SRA, K_SYS, K_MFHI, K_MTHI, K_MFLO, K_MTLO, K_MULT, K_DIV,
    K_ADD, K_SUB, K_AND, K_OR, K_XOR, K_NOR, K_BEQ, K_BNE, K_ADDI, K_ANDI,
    K_ORI, K_XORI, K_LB, K_LH, K_LW, K_SB, K_SH, K_SW, K_ILL
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  dst;
    logic [4:0]  shamt;
    logic [15:0] imm;
  } dec_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_write;
    logic [31:0] mem_address;
    logic        syscall_seen;
    logic        illegal_op;
  } result_t;

endpackage

[design/mips_subset_execute_core_unit.sv]
// top level of the execute core: front end, instruction queue, back end
// depends on msec_pkg, msec_front, msec_fifo, msec_back
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  s_tdata[31:0] instruction
// m_*      out  m_tvalid/m_tready  m_tdata[104:0] result, [111:105] zero
// cfg_*    in   cfg_valid/ready    cfg_data start_address (also loads pc)
//
// back end steps alu/branch ops through idle, read, wb; loads/stores add mem
// (data memory read then merge/write), div adds div (one quotient bit a cycle)
// the queue takes words until full while the back end works or output stalls
// synchronous reset clears pc, hi, lo, rf valid bits; data memory is not reset
module mips_subset_execute_core_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [31:0]               s_tdata,   // instruction
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // next_pc, reg_write, reg_index, reg_value, mem_write, mem_address,
  // syscall_seen, illegal_op, zero fill
  output logic [msec_pkg::OUT_W-1:0] m_tdata,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [31:0]               cfg_data
);
  import msec_pkg::*;

  dec_t    dec;
  dec_t    q_head;
  logic    q_full;
  logic    q_empty;
  logic    q_push;
  logic    q_pop;
  result_t res;

  assign cfg_ready = 1'b1;

  msec_front u_front (
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .instruction (s_tdata),
    .q_full      (q_full),
    .q_push      (q_push),
    .dec         (dec)
  );

  msec_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (dec),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (q_head)
  );

  msec_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .res       (res)
  );

  assign m_tdata = {7'd0, res.illegal_op, res.syscall_seen, res.mem_address,
                    res.mem_write, res.reg_value, res.reg_index, res.reg_write,
                    res.next_pc};

endmodule

[design/msec_front.sv]
// front end: accepts instruction words and classifies them
// depends on msec_pkg
module msec_front (
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [31:0]   instruction,
  input  logic          q_full,
  output logic          q_push,
  output msec_pkg::dec_t dec
);
  import msec_pkg::*;

  logic [5:0] opc;
  logic [5:0] fn;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;
  assign opc      = instruction[31:26];
  assign fn       = instruction[5:0];

  always_comb begin
    dec.rs    = instruction[25:21];
    dec.rt    = instruction[20:16];
    dec.dst   = instruction[20:16];
    dec.shamt = instruction[10:6];
    dec.imm   = instruction[15:0];
    dec.kind  = K_ILL;
    unique case (opc)
      OPC_SPECIAL: begin
        dec.dst = instruction[15:11];
        unique case (fn)
          FN_SLL:     dec.kind = K_SLL;
          FN_SRL:     dec.kind = K_SRL;
          FN_SRA:     dec.kind = K_SRA;
          FN_SYSCALL: dec.kind = K_SYS;
          FN_MFHI:    dec.kind = K_MFHI;
          FN_MTHI:    dec.kind = K_MTHI;
          FN_MFLO:    dec.kind = K_MFLO;
          FN_MTLO:    dec.kind = K_MTLO;
          FN_MULT:    dec.kind = K_MULT;
          FN_DIV:     dec.kind = K_DIV;
          FN_ADD:     dec.kind = K_ADD;
          FN_SUB:     dec.kind = K_SUB;
          FN_AND:     dec.kind = K_AND;
          FN_OR:      dec.kind = K_OR;
          FN_XOR:     dec.kind = K_XOR;
          FN_NOR:     dec.kind = K_NOR;
          default:    dec.kind = K_ILL;
        endcase
      end
      OPC_BEQ:  dec.kind = K_BEQ;
      OPC_BNE:  dec.kind = K_BNE;
      OPC_ADDI: dec.kind = K_ADDI;
      OPC_ANDI: dec.kind = K_ANDI;
      OPC_ORI:  dec.kind = K_ORI;
      OPC_XORI: dec.kind = K_XORI;
      OPC_LB:   dec.kind = K_LB;
      OPC_LH:   dec.kind = K_LH;
      OPC_LW:   dec.kind = K_LW;
      OPC_SB:   dec.kind = K_SB;
      OPC_SH:   dec.kind = K_SH;
      OPC_SW:   dec.kind = K_SW;
      default:  dec.kind = K_ILL;
    endcase
  end

endmodule

[design/msec_fifo.sv]
// short queue of decoded instructions between front and back end
// depends on msec_pkg
module msec_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  msec_pkg::dec_t din,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output msec_pkg::dec_t dout
);
  import msec_pkg::*;

  dec_t                slot [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;

  assign full  = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign dout  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QUEUE_CW'(push) - QUEUE_CW'(pop);
    end
  end

endmodule

[design/msec_div.sv]
// signed 32-bit divider, one quotient bit per cycle
// no dependencies
module msec_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);

  localparam int STEPS = 32;
  localparam int CW    = $clog2(STEPS);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [31:0]   rem;
  logic [31:0]   quo;
  logic [31:0]   dv;
  logic          neg_q;
  logic          neg_r;
  logic [32:0]   shifted;
  logic [32:0]   diff;

  assign shifted   = {rem, quo[31]};
  assign diff      = shifted - {1'b0, dv};
  assign quotient  = neg_q ? (32'd0 - quo) : quo;
  assign remainder = neg_r ? (32'd0 - rem) : rem;

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= dividend[31] ? (32'd0 - dividend) : dividend;
      dv    <= divisor[31] ? (32'd0 - divisor) : divisor;
      rem   <= '0;
      neg_q <= dividend[31] ^ divisor[31];
      neg_r <= dividend[31];
    end else if (busy) begin
      // restoring step on magnitudes
      rem <= diff[32] ? shifted[31:0] : diff[31:0];
      quo <= {quo[30:0], ~diff[32]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CW'(STEPS - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

[design/msec_back.sv]
// back end: register file, hi/lo, pc, data memory and the execute sequencer
// depends on msec_pkg, msec_div and the assertion header
`include "mips_subset_execute_core_unit_assert.svh"

module msec_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  msec_pkg::dec_t    q_head,
  output logic              q_pop,
  input  logic              cfg_valid,
  input  logic [31:0]       cfg_data,
  output logic              m_tvalid,
  input  logic              m_tready,
  output msec_pkg::result_t res
);
  import msec_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_MEM  = 5'b00100,
    S_DIV  = 5'b01000,
    S_WB   = 5'b10000
  } state_t;

  state_t      state;
  state_t      state_next;
  dec_t        item;
  logic [31:0] pc;
  logic [31:0] hi;
  logic [31:0] lo;
  logic [31:0] rf [32];
  logic [31:0] rf_vld;
  logic [31:0] rd_a;
  logic [31:0] rd_b;
  logic        va;
  logic        vb;
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] dmem [DMEM_WORDS];
  logic [31:0] dm_q;

  logic [31:0] r_npc;
  logic        r_wr;
  logic [4:0]  r_widx;
  logic [31:0] r_wval;
  logic        r_mw;
  logic [31:0] r_ea;
  logic        r_sys;
  logic        r_ill;
  logic [63:0] prod;

  logic [31:0] simm;
  logic [31:0] zimm;
  logic [31:0] ea;
  logic [31:0] pc4;
  logic        taken;
  logic        wr_c;
  logic [31:0] wval_c;
  logic        is_mem;
  logic        is_store;
  logic        is_load;
  logic        adv;
  logic        rf_we;
  logic [31:0] ld_val;
  logic [31:0] st_word;
  logic        div_start;
  logic        div_done;
  logic [31:0] div_q;
  logic [31:0] div_r;

  assign a    = va ? rd_a : 32'd0;
  assign b    = vb ? rd_b : 32'd0;
  assign simm = {{16{item.imm[15]}}, item.imm};
  assign zimm = {16'd0, item.imm};
  assign ea   = a + simm;
  assign pc4  = pc + 32'd4;

  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign adv       = (state == S_WB) && (!m_tvalid || m_tready);
  assign rf_we     = adv && r_wr;
  assign div_start = (state == S_READ) && (item.kind == K_DIV);

  always_comb begin
    is_load  = 1'b0;
    is_store = 1'b0;
    case (item.kind)
      K_LB, K_LH, K_LW: is_load = 1'b1;
      K_SB, K_SH, K_SW: is_store = 1'b1;
      default: ;
    endcase
    is_mem = is_load || is_store;
  end

  // alu, shifts, branch compare
  always_comb begin
    wr_c   = 1'b1;
    wval_c = 32'd0;
    taken  = 1'b0;
    unique case (item.kind)
      K_SLL:  wval_c = b << item.shamt;
      K_SRL:  wval_c = b >> item.shamt;
      K_SRA:  wval_c = 32'($signed(b) >>> item.shamt);
      K_MFHI: wval_c = hi;
      K_MFLO: wval_c = lo;
      K_ADD:  wval_c = a + b;
      K_SUB:  wval_c = a - b;
      K_AND:  wval_c = a & b;
      K_OR:   wval_c = a | b;
      K_XOR:  wval_c = a ^ b;
      K_NOR:  wval_c = ~(a | b);
      K_ADDI: wval_c = a + simm;
      K_ANDI: wval_c = a & zimm;
      K_ORI:  wval_c = a | zimm;
      K_XORI: wval_c = a ^ zimm;
      K_LB, K_LH, K_LW: wval_c = 32'd0;
      K_BEQ: begin
        wr_c  = 1'b0;
        taken = (a == b);
      end
      K_BNE: begin
        wr_c  = 1'b0;
        taken = (a != b);
      end
      default: wr_c = 1'b0;
    endcase
  end

  // load extraction and store merge, little-endian lanes
  always_comb begin
    ld_val  = dm_q;
    st_word = b;
    case (item.kind)
      K_LB: begin
        case (r_ea[1:0])
          2'd0:    ld_val = {{24{dm_q[7]}}, dm_q[7:0]};
          2'd1:    ld_val = {{24{dm_q[15]}}, dm_q[15:8]};
          2'd2:    ld_val = {{24{dm_q[23]}}, dm_q[23:16]};
          default: ld_val = {{24{dm_q[31]}}, dm_q[31:24]};
        endcase
      end
      K_LH: ld_val = r_ea[1] ? {{16{dm_q[31]}}, dm_q[31:16]}
                             : {{16{dm_q[15]}}, dm_q[15:0]};
      K_SB: begin
        case (r_ea[1:0])
          2'd0:    st_word = {dm_q[31:8], b[7:0]};
          2'd1:    st_word = {dm_q[31:16], b[7:0], dm_q[7:0]};
          2'd2:    st_word = {dm_q[31:24], b[7:0], dm_q[15:0]};
          default: st_word = {b[7:0], dm_q[23:0]};
        endcase
      end
      K_SH: st_word = r_ea[1] ? {b[15:0], dm_q[15:0]} : {dm_q[31:16], b[15:0]};
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (!q_empty) state_next = S_READ;
      S_READ: begin
        if (item.kind == K_DIV) begin
          state_next = S_DIV;
        end else if (is_mem) begin
          state_next = S_MEM;
        end else begin
          state_next = S_WB;
        end
      end
      S_MEM:  state_next = S_WB;
      S_DIV:  if (div_done) state_next = S_WB;
      S_WB:   if (adv) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  msec_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (a),
    .divisor   (b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // register file and data memory arrays
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_a <= rf[q_head.rs];
      rd_b <= rf[q_head.rt];
    end
    if (rf_we) begin
      rf[r_widx] <= r_wval;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      dm_q <= dmem[ea[DMEM_AW+1:2]];
    end
    if ((state == S_MEM) && is_store) begin
      dmem[r_ea[DMEM_AW+1:2]] <= st_word;
    end
  end

  // item datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item <= q_head;
      va   <= rf_vld[q_head.rs];
      vb   <= rf_vld[q_head.rt];
    end
    if (state == S_READ) begin
      r_npc  <= taken ? (pc4 + {simm[29:0], 2'b00}) : pc4;
      r_wr   <= (wr_c || is_load) && (item.dst != 5'd0);
      r_widx <= item.dst;
      r_wval <= (item.dst != 5'd0) ? wval_c : 32'd0;
      r_mw   <= is_store;
      r_ea   <= is_mem ? ea : 32'd0;
      r_sys  <= (item.kind == K_SYS);
      r_ill  <= (item.kind == K_ILL);
      prod   <= 64'($signed(a) * $signed(b));
    end
    if ((state == S_MEM) && is_load && (item.dst != 5'd0)) begin
      r_wval <= ld_val;
    end
    if (adv) begin
      res.next_pc      <= r_npc;
      res.reg_write    <= r_wr;
      res.reg_index    <= r_wr ? r_widx : 5'd0;
      res.reg_value    <= r_wval;
      res.mem_write    <= r_mw;
      res.mem_address  <= r_ea;
      res.syscall_seen <= r_sys;
      res.illegal_op   <= r_ill;
    end
  end

  // architectural state with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pc       <= 32'd0;
      hi       <= 32'd0;
      lo       <= 32'd0;
      rf_vld   <= 32'd0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        pc <= {cfg_data[31:2], 2'b00};
      end
      if (adv) begin
        m_tvalid <= 1'b1;
        pc       <= r_npc;
        case (item.kind)
          K_MTHI: hi <= a;
          K_MTLO: lo <= a;
          K_MULT: begin
            hi <= prod[63:32];
            lo <= prod[31:0];
          end
          K_DIV: begin
            if (b != 32'd0) begin
              hi <= div_r;
              lo <= div_q;
            end
          end
          default: ;
        endcase
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (rf_we) begin
        rf_vld[r_widx] <= 1'b1;
      end
    end
  end

  `MSEC_NEVER(a_no_zero_write, rf_we && (r_widx == 5'd0), "write to register zero")
  `MSEC_ASSERT(a_div_done_wait, div_done |-> (state == S_DIV), "divider finished out of turn")
  `MSEC_ASSERT(a_wb_hold, ((state == S_WB) && m_tvalid && !m_tready) |=> (state == S_WB), "result overrun")
  `MSEC_ASSERT(a_read_after_pop, (state == S_READ) |-> ($past(state) == S_IDLE), "read without pop")

endmodule

[test/tb_mips_subset_execute_core_unit.sv]
// testbench for the mips subset execute core: directed and random instruction streams
// predicts each result with an in-class model of the architected state; uses msec_pkg
`timescale 1ns / 100ps

class exec_scoreboard;
  logic [31:0] regs[32];
  logic [31:0] hi, lo, pc;
  logic [31:0] dmem[msec_pkg::DMEM_WORDS];
  bit dmem_valid[msec_pkg::DMEM_WORDS];
  int written_slots[$];
  msec_pkg::result_t expected_q[$];
  int errors;

  function void clear_state();
    foreach (regs[i]) regs[i] = '0;
    foreach (dmem_valid[i]) dmem_valid[i] = 0;
    written_slots.delete();
    hi = '0;
    lo = '0;
    pc = '0;
  endfunction

  function void load_start(logic [31:0] v);
    pc = {v[31:2], 2'b00};
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function void note_instruction(logic [31:0] ins);
    logic [5:0] op, fn;
    logic [4:0] rs, rt, rd, sh;
    logic [31:0] a, b, simm, zimm, npc, ea, w, wval, q, r, ma, mb;
    logic [63:0] prod;
    logic [7:0] bt;
    logic [15:0] hw;
    int slot, bsh, hsh;
    bit wr, mw, sys, ill, mem;
    logic [4:0] widx;
    msec_pkg::result_t res;
    op = ins[31:26]; rs = ins[25:21]; rt = ins[20:16]; rd = ins[15:11];
    sh = ins[10:6]; fn = ins[5:0];
    a = regs[rs]; b = regs[rt];
    simm = {{16{ins[15]}}, ins[15:0]};
    zimm = {16'h0, ins[15:0]};
    npc = pc + 32'd4;
    ea = a + simm;
    slot = (ea >> 2) % msec_pkg::DMEM_WORDS;
    w = dmem_valid[slot] ? dmem[slot] : 32'h0;
    bsh = ea[1:0] * 8;
    hsh = ea[1] * 16;
    wr = 0; mw = 0; sys = 0; ill = 0; mem = 0; widx = '0; wval = '0;
    if (op == msec_pkg::OPC_SPECIAL) begin
      widx = rd;
      case (fn)
        msec_pkg::FN_SLL: begin wr = 1; wval = b << sh; end
        msec_pkg::FN_SRL: begin wr = 1; wval = b >> sh; end
        msec_pkg::FN_SRA: begin wr = 1; wval = $signed(b) >>> sh; end
        msec_pkg::FN_SYSCALL: sys = 1;
        msec_pkg::FN_MFHI: begin wr = 1; wval = hi; end
        msec_pkg::FN_MTHI: hi = a;
        msec_pkg::FN_MFLO: begin wr = 1; wval = lo; end
        msec_pkg::FN_MTLO: lo = a;
        msec_pkg::FN_MULT: begin
          prod = {{32{a[31]}}, a} * {{32{b[31]}}, b};
          lo = prod[31:0];
          hi = prod[63:32];
        end
        msec_pkg::FN_DIV: begin
          if (b != 0) begin
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            q = ma / mb;
            r = ma % mb;
            lo = (a[31] ^ b[31]) ? -q : q;
            hi = a[31] ? -r : r;
          end
        end
        msec_pkg::FN_ADD: begin wr = 1; wval = a + b; end
        msec_pkg::FN_SUB: begin wr = 1; wval = a - b; end
        msec_pkg::FN_AND: begin wr = 1; wval = a & b; end
        msec_pkg::FN_OR:  begin wr = 1; wval = a | b; end
        msec_pkg::FN_XOR: begin wr = 1; wval = a ^ b; end
        msec_pkg::FN_NOR: begin wr = 1; wval = ~(a | b); end
        default: ill = 1;
      endcase
    end else begin
      widx = rt;
      case (op)
        msec_pkg::OPC_BEQ: if (a == b) npc = npc + (simm << 2);
        msec_pkg::OPC_BNE: if (a != b) npc = npc + (simm << 2);
        msec_pkg::OPC_ADDI: begin wr = 1; wval = a + simm; end
        msec_pkg::OPC_ANDI: begin wr = 1; wval = a & zimm; end
        msec_pkg::OPC_ORI:  begin wr = 1; wval = a | zimm; end
        msec_pkg::OPC_XORI: begin wr = 1; wval = a ^ zimm; end
        msec_pkg::OPC_LB: begin
          mem = 1; wr = 1; bt = 8'(w >> bsh);
          wval = {{24{bt[7]}}, bt};
        end
        msec_pkg::OPC_LH: begin
          mem = 1; wr = 1; hw = 16'(w >> hsh);
          wval = {{16{hw[15]}}, hw};
        end
        msec_pkg::OPC_LW: begin mem = 1; wr = 1; wval = w; end
        msec_pkg::OPC_SB: begin
          mem = 1; mw = 1;
          dmem[slot] = (w & ~(32'hFF << bsh)) | ((b & 32'hFF) << bsh);
        end
        msec_pkg::OPC_SH: begin
          mem = 1; mw = 1;
          dmem[slot] = (w & ~(32'hFFFF << hsh)) | ((b & 32'hFFFF) << hsh);
        end
        msec_pkg::OPC_SW: begin mem = 1; mw = 1; dmem[slot] = b; end
        default: ill = 1;
      endcase
      if (mw && !dmem_valid[slot]) begin
        dmem_valid[slot] = 1;
        written_slots.push_back(slot);
      end
    end
    // register zero swallows writes
    if (wr && widx == 0) wr = 0;
    if (wr) regs[widx] = wval;
    pc = npc;
    res.next_pc = npc;
    res.reg_write = wr;
    res.reg_index = wr ? widx : 5'd0;
    res.reg_value = wr ? wval : 32'd0;
    res.mem_write = mw;
    res.mem_address = mem ? ea : 32'd0;
    res.syscall_seen = sys;
    res.illegal_op = ill;
    expected_q.push_back(res);
  endfunction

  task check_result(logic [msec_pkg::OUT_W-1:0] d);
    msec_pkg::result_t e;
    if (expected_q.size() == 0) begin
      report($sformatf("result with none expected, tdata %h", d));
    end else begin
      e = expected_q.pop_front();
      if (d[31:0] !== e.next_pc)
        report($sformatf("next_pc %h exp %h", d[31:0], e.next_pc));
      if (d[32] !== e.reg_write)
        report($sformatf("reg_write %b exp %b", d[32], e.reg_write));
      if (d[37:33] !== e.reg_index)
        report($sformatf("reg_index %0d exp %0d", d[37:33], e.reg_index));
      if (d[69:38] !== e.reg_value)
        report($sformatf("reg_value %h exp %h", d[69:38], e.reg_value));
      if (d[70] !== e.mem_write)
        report($sformatf("mem_write %b exp %b", d[70], e.mem_write));
      if (d[102:71] !== e.mem_address)
        report($sformatf("mem_address %h exp %h", d[102:71], e.mem_address));
      if (d[103] !== e.syscall_seen)
        report($sformatf("syscall_seen %b exp %b", d[103], e.syscall_seen));
      if (d[104] !== e.illegal_op)
        report($sformatf("illegal_op %b exp %b", d[104], e.illegal_op));
    end
  endtask
endclass

module tb_mips_subset_execute_core_unit;
  import msec_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 80;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [31:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;

  exec_scoreboard exec_sb = new();
  int cycles = 0;
  int burst_left = 0;

  mips_subset_execute_core_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver stall pattern: free running, random, then mostly stalled
  always @(negedge clk) begin
    case ((cycles / 700) % 3)
      0: m_tready = 1;
      1: m_tready = ($urandom_range(0, 9) < 7);
      default: m_tready = ((cycles % 4) == 0);
    endcase
  end

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) exec_sb.check_result(m_tdata);

  function automatic logic [31:0] rtype(int rs, int rt, int rd, int sh, logic [5:0] fn);
    rtype = {OPC_SPECIAL, 5'(rs), 5'(rt), 5'(rd), 5'(sh), fn};
  endfunction

  function automatic logic [31:0] itype(logic [5:0] op, int rs, int rt, logic [15:0] imm);
    itype = {op, 5'(rs), 5'(rt), imm};
  endfunction

  function automatic bit is_supported(logic [31:0] ins);
    logic [5:0] fn;
    fn = ins[5:0];
    if (ins[31:26] == OPC_SPECIAL)
      return fn inside {FN_SLL, FN_SRL, FN_SRA, FN_SYSCALL, FN_MFHI, FN_MTHI,
                        FN_MFLO, FN_MTLO, FN_MULT, FN_DIV, FN_ADD, FN_SUB,
                        FN_AND, FN_OR, FN_XOR, FN_NOR};
    return ins[31:26] inside {OPC_BEQ, OPC_BNE, OPC_ADDI, OPC_ANDI, OPC_ORI,
                              OPC_XORI, OPC_LB, OPC_LH, OPC_LW, OPC_SB,
                              OPC_SH, OPC_SW};
  endfunction

  // load or store aimed at a slot: low 12 bits of the immediate steer the address
  function automatic logic [31:0] mem_access(logic [5:0] op, int slot);
    int rs;
    logic [11:0] ea_lo, imm_lo;
    rs = $urandom_range(0, 31);
    ea_lo = {10'(slot), 2'($urandom_range(0, 3))};
    imm_lo = ea_lo - exec_sb.regs[rs][11:0];
    return itype(op, rs, $urandom_range(0, 31), {4'($urandom_range(0, 15)), imm_lo});
  endfunction

  function automatic logic [31:0] random_instruction();
    int pick, rs, rt, slot;
    logic [31:0] ins;
    logic [5:0] loads[5];
    logic [5:0] alu_fn[9];
    logic [5:0] imm_op[4];
    logic [5:0] hilo_fn[6];
    loads = '{OPC_LB, OPC_LH, OPC_LW, OPC_SB, OPC_SH};
    alu_fn = '{FN_SLL, FN_SRL, FN_SRA, FN_ADD, FN_SUB, FN_AND, FN_OR, FN_XOR, FN_NOR};
    imm_op = '{OPC_ADDI, OPC_ANDI, OPC_ORI, OPC_XORI};
    hilo_fn = '{FN_MULT, FN_DIV, FN_MTHI, FN_MTLO, FN_MFHI, FN_MFLO};
    pick = $urandom_range(0, 99);
    rs = $urandom_range(0, 31);
    rt = $urandom_range(0, 31);
    if (pick < 6) begin
      do ins = $urandom(); while (is_supported(ins));
    end else if (pick < 10) begin
      ins = rtype(rs, rt, $urandom_range(0, 31), $urandom_range(0, 31), FN_SYSCALL);
      if (pick < 8) ins[25:6] = 20'($urandom());
    end else if (pick < 24) begin
      if (exec_sb.written_slots.size() == 0 || $urandom_range(0, 3) == 0)
        ins = mem_access(OPC_SW, $urandom_range(0, DMEM_WORDS - 1));
      else begin
        slot = exec_sb.written_slots[$urandom_range(0, exec_sb.written_slots.size() - 1)];
        ins = mem_access(loads[$urandom_range(0, 4)], slot);
      end
    end else if (pick < 34) begin
      ins = rtype(rs, rt, $urandom_range(0, 31), $urandom_range(0, 31),
                  hilo_fn[$urandom_range(0, 5)]);
    end else if (pick < 44) begin
      if ($urandom_range(0, 1)) rt = rs;
      ins = itype($urandom_range(0, 1) ? OPC_BEQ : OPC_BNE, rs, rt, 16'($urandom()));
    end else if (pick < 70) begin
      ins = rtype(rs, rt, $urandom_range(0, 31), $urandom_range(0, 31),
                  alu_fn[$urandom_range(0, 8)]);
    end else begin
      ins = itype(imm_op[$urandom_range(0, 3)], rs, rt, 16'($urandom()));
    end
    return ins;
  endfunction

  task send_instruction(logic [31:0] ins);
    @(negedge clk);
    if (burst_left == 0) begin
      s_tvalid = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 20);
    end
    burst_left--;
    s_tvalid = 1;
    s_tdata = ins;
    do @(posedge clk); while (!s_tready);
    exec_sb.note_instruction(ins);
  endtask

  task wait_idle();
    @(negedge clk);
    s_tvalid = 0;
    while (exec_sb.expected_q.size() != 0) @(posedge clk);
    // quiet gap before the next configuration write
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_start(logic [31:0] v);
    @(negedge clk);
    cfg_valid = 1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    exec_sb.load_start(v);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  initial begin
    logic [31:0] directed[$];
    logic [31:0] starts[4];
    exec_sb.clear_state();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    directed = '{
      32'h0000_0000,                                 // sll into register zero
      itype(OPC_ORI, 0, 1, 16'hFFFF),
      rtype(7, 1, 2, 16, FN_SLL),                    // unused rs field set
      itype(OPC_ORI, 0, 3, 16'h8000),
      rtype(0, 3, 3, 16, FN_SLL),
      itype(OPC_ADDI, 0, 4, 16'hFFFF),
      rtype(3, 4, 0, 0, FN_DIV),                     // most negative over minus one
      rtype(0, 0, 5, 0, FN_MFLO),
      rtype(0, 0, 6, 0, FN_MFHI),
      rtype(1, 0, 0, 31, FN_DIV),                    // divide by zero keeps hi/lo
      rtype(3, 4, 0, 0, FN_MULT),
      rtype(0, 0, 8, 0, FN_MFHI),
      rtype(0, 3, 9, 31, FN_SRA),
      rtype(0, 3, 10, 31, FN_SRL),
      itype(OPC_SW, 0, 2, 16'hFFFF),                 // misaligned, beyond memory
      itype(OPC_LB, 0, 11, 16'hFFFF),
      itype(OPC_LH, 0, 12, 16'hFFFD),
      itype(OPC_SB, 4, 3, 16'h0000),
      itype(OPC_SH, 0, 1, 16'hFFFE),
      itype(OPC_LW, 0, 13, 16'h7FFF ^ 16'h8000),
      itype(OPC_ADDI, 1, 0, 16'h7FFF),               // write to register zero dropped
      itype(OPC_XORI, 3, 14, 16'hFFFF),
      itype(OPC_BEQ, 0, 0, 16'hFFFF),
      itype(OPC_BNE, 1, 0, 16'h7FFF),
      rtype(31, 31, 31, 31, FN_SYSCALL),
      32'h0800_0010,                                 // jump is not supported
      32'h7000_0002,                                 // special2 is not supported
      32'hFFFF_FFFF
    };

    starts = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom(), 32'h7FFF_FFFC};
    for (int ph = 0; ph < 4; ph++) begin
      write_start(starts[ph]);
      if (ph == 0)
        foreach (directed[i]) send_instruction(directed[i]);
      for (int n = 0; n < 335; n++) send_instruction(random_instruction());
      wait_idle();
    end

    if (exec_sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+design
design/msec_pkg.sv
design/msec_front.sv
design/msec_fifo.sv
design/msec_div.sv
design/msec_back.sv
design/mips_subset_execute_core_unit.sv
test/tb_mips_subset_execute_core_unit.sv
